>>> design/bitmap_run_allocator_core_macros.svh
// assertion macros used by the allocator core
`ifndef BITMAP_RUN_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_RUN_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define BRAC_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed: same-cycle rule");

// next-cycle implication, checked outside reset
`define BRAC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed: next-cycle rule");

`endif

>>> design/brac_pkg.sv
// shared constants, codes and types of the bitmap run allocator
package brac_pkg;

    // map geometry
    localparam int MAP_BITS  = 4096;
    localparam int WORD_W    = 32;
    localparam int MAP_WORDS = MAP_BITS / WORD_W;
    localparam int MAP_BYTES = MAP_BITS / 8;
    localparam int WADDR_W   = $clog2(MAP_WORDS);
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int REL_W     = $clog2(MAP_BITS);
    localparam int BCNT_W    = $clog2(MAP_BYTES + 1);
    localparam int NBITS_W   = BCNT_W + 3;

    // field widths
    localparam int IDX_W    = 32;
    localparam int FUNC_W   = 2;
    localparam int RUN_W    = 13;
    localparam int BYTES_W  = 10;
    localparam int STATUS_W = 2;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_BASE_INDEX   = 1'b0;
    localparam logic REG_BYTES_IN_USE = 1'b1;
    localparam logic [BYTES_W-1:0] BYTES_RESET = BYTES_W'(MAP_BYTES);

    // operation codes
    localparam logic [FUNC_W-1:0] FN_TEST = 2'd0;
    localparam logic [FUNC_W-1:0] FN_SET  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_SCAN = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

    typedef struct packed {
        logic [IDX_W-1:0]   base_index;
        logic [BYTES_W-1:0] bytes_in_use;
    } cfg_t;

    typedef struct packed {
        logic               re;
        logic [WADDR_W-1:0] raddr;
        logic               we;
        logic [WADDR_W-1:0] waddr;
        logic [WORD_W-1:0]  wdata;
    } mem_req_t;

    typedef struct packed {
        logic             hit;
        logic [2:0]       hit_pos;
        logic [RUN_W-1:0] run_out;
    } scan_res_t;

endpackage

>>> design/brac_in_if.sv
// request channel: one operation per item
interface brac_in_if;
    logic                         valid;
    logic                         ready;
    logic [brac_pkg::FUNC_W-1:0]  func;
    logic [brac_pkg::IDX_W-1:0]   index;
    logic                         new_value;
    logic [brac_pkg::RUN_W-1:0]   run_length;

    modport source (output valid, func, index, new_value, run_length, input ready);
    modport sink (input valid, func, index, new_value, run_length, output ready);
endinterface

>>> design/brac_out_if.sv
// response channel: one result per item
interface brac_out_if;
    logic                          valid;
    logic                          ready;
    logic                          bit_value;
    logic [brac_pkg::STATUS_W-1:0] status;
    logic [brac_pkg::IDX_W-1:0]    start_index;

    modport source (output valid, bit_value, status, start_index, input ready);
    modport sink (input valid, bit_value, status, start_index, output ready);
endinterface

>>> design/brac_cfg_regs.sv
// apb configuration registers: base index and bytes in use
module brac_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [brac_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [brac_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [brac_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output brac_pkg::cfg_t                      cfg
);

    logic [brac_pkg::IDX_W-1:0]   base_reg;
    logic [brac_pkg::BYTES_W-1:0] bytes_reg;
    logic                         wr_en;
    logic                         reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            bytes_reg <= brac_pkg::BYTES_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                brac_pkg::REG_BASE_INDEX:   base_reg  <= pwdata[brac_pkg::IDX_W-1:0];
                brac_pkg::REG_BYTES_IN_USE: bytes_reg <= pwdata[brac_pkg::BYTES_W-1:0];
                default:                    base_reg  <= base_reg;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (reg_sel)
            brac_pkg::REG_BASE_INDEX:   prdata = brac_pkg::APB_DATA_W'(base_reg);
            brac_pkg::REG_BYTES_IN_USE: prdata = brac_pkg::APB_DATA_W'(bytes_reg);
            default:                    prdata = '0;
        endcase
    end

    assign cfg.base_index   = base_reg;
    assign cfg.bytes_in_use = bytes_reg;

endmodule

>>> design/brac_map_store.sv
// map memory: one read and one write port, per-word valid bits clear it at reset
module brac_map_store (
    input  logic                            clk,
    input  logic                            rst_n,
    input  brac_pkg::mem_req_t              req,
    output logic [brac_pkg::WORD_W-1:0]     rdata
);

    logic [brac_pkg::WORD_W-1:0]    mem [brac_pkg::MAP_WORDS];
    logic [brac_pkg::MAP_WORDS-1:0] vld_reg;
    logic [brac_pkg::WORD_W-1:0]    rd_word_reg;
    logic                           rd_vld_reg;

    // storage array, no reset
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_word_reg <= mem[req.raddr];
        end
    end

    // written marks, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                vld_reg[req.waddr] <= 1'b1;
            end
            if (req.re)
            begin
                rd_vld_reg <= vld_reg[req.raddr];
            end
        end
    end

    // a word never written reads as all clear
    assign rdata = rd_vld_reg ? rd_word_reg : '0;

endmodule

>>> design/brac_byte_scan.sv
// run counter over one map byte, lowest bit first
module brac_byte_scan (
    input  logic [7:0]                    byte_bits,
    input  logic [brac_pkg::RUN_W-1:0]    run_in,
    input  logic [brac_pkg::RUN_W-1:0]    want,
    output brac_pkg::scan_res_t           res
);

    always_comb
    begin
        logic [brac_pkg::RUN_W-1:0] run;
        logic                       hit;
        logic [2:0]                 pos;
        run = run_in;
        hit = 1'b0;
        pos = '0;
        // a set bit restarts the run; first position that reaches the want wins
        for (int j = 0; j < 8; j++)
        begin
            run = byte_bits[j] ? '0 : run + 1'b1;
            if (!hit && (run == want))
            begin
                hit = 1'b1;
                pos = 3'(j);
            end
        end
        res.hit     = hit;
        res.hit_pos = pos;
        res.run_out = run;
    end

endmodule

>>> design/bitmap_run_allocator_core.sv
// Bitmap first-fit allocator over a 4096-bit map held in a 128 x 32 synchronous memory.
// Test and set: an accepted item goes from lookup through execute to the result state
// (lookup goes straight to result on a range error or unused code). Scan: the byte
// scanner walks the map bytes one per cycle, then the run words are written back one
// per cycle. A new item is taken only in idle. Reset (rst_n low, asynchronous) clears control,
// the configuration registers and the per-word valid marks, so the whole map reads as clear at once.
`include "bitmap_run_allocator_core_macros.svh"

module bitmap_run_allocator_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [brac_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [brac_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [brac_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    brac_in_if.sink                           req,
    brac_out_if.source                        rsp
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LOOKUP = 6'b000010,
        S_EXEC   = 6'b000100,
        S_SCAN   = 6'b001000,
        S_FILL   = 6'b010000,
        S_RESULT = 6'b100000
    } state_t;

    brac_pkg::cfg_t      cfg;
    brac_pkg::mem_req_t  mem_req;
    brac_pkg::scan_res_t scan_res;
    logic [brac_pkg::WORD_W-1:0] rdata;

    state_t state_reg, state_next;

    // accepted item
    logic [brac_pkg::FUNC_W-1:0] func_reg;
    logic [brac_pkg::IDX_W-1:0]  index_reg;
    logic                        nv_reg;
    logic [brac_pkg::RUN_W-1:0]  want_reg;

    // work registers
    logic [brac_pkg::REL_W-1:0]   rel_reg, rel_next;
    logic [brac_pkg::BCNT_W-1:0]  bcnt_reg, bcnt_next;
    logic [brac_pkg::RUN_W-1:0]   run_reg, run_next;
    logic [brac_pkg::REL_W-1:0]   start_rel_reg, start_rel_next;
    logic [brac_pkg::REL_W-1:0]   end_rel_reg, end_rel_next;
    logic [brac_pkg::WADDR_W-1:0] fw_reg, fw_next;

    // pending result
    logic                          res_bit_reg, res_bit_next;
    logic [brac_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [brac_pkg::IDX_W-1:0]    res_start_reg, res_start_next;

    // output register
    logic                          out_valid_reg;
    logic                          out_bit_reg;
    logic [brac_pkg::STATUS_W-1:0] out_status_reg;
    logic [brac_pkg::IDX_W-1:0]    out_start_reg;
    logic                          load_out;

    // helpers
    logic                          in_accept;
    logic [brac_pkg::BCNT_W-1:0]   nbytes_eff;
    logic [brac_pkg::NBITS_W-1:0]  nbits;
    logic [brac_pkg::IDX_W-1:0]    diff;
    logic                          in_range;
    logic [brac_pkg::BCNT_W-1:0]   bcnt_inc;
    logic [7:0]                    cur_byte;
    logic [brac_pkg::REL_W-1:0]    hit_end;
    logic [brac_pkg::RUN_W-1:0]    hit_start_full;
    logic [brac_pkg::REL_W-1:0]    hit_start;
    logic [brac_pkg::WORD_W-1:0]   bit_mask;
    logic [brac_pkg::BIT_W-1:0]    fill_lo;
    logic [brac_pkg::BIT_W-1:0]    fill_hi;
    logic [brac_pkg::WORD_W-1:0]   fill_mask;
    logic                          fill_last;

    brac_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    brac_map_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (rdata)
    );

    brac_byte_scan u_scan (
        .byte_bits (cur_byte),
        .run_in    (run_reg),
        .want      (want_reg),
        .res       (scan_res)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign in_accept = req.valid && req.ready;

    // bytes in use, limited to the map size
    assign nbytes_eff = (32'(cfg.bytes_in_use) > 32'(brac_pkg::MAP_BYTES))
                      ? brac_pkg::BCNT_W'(brac_pkg::MAP_BYTES)
                      : brac_pkg::BCNT_W'(cfg.bytes_in_use);
    assign nbits      = {nbytes_eff, 3'b000};

    // index relative to the base, range check
    assign diff     = index_reg - cfg.base_index;
    assign in_range = (index_reg >= cfg.base_index) && (diff < 32'(nbits));

    // scan datapath
    assign bcnt_inc       = bcnt_reg + 1'b1;
    assign cur_byte       = rdata[{bcnt_reg[1:0], 3'b000} +: 8];
    assign hit_end        = {bcnt_reg[brac_pkg::REL_W-4:0], scan_res.hit_pos};
    assign hit_start_full = brac_pkg::RUN_W'(hit_end) + 1'b1 - want_reg;
    assign hit_start      = hit_start_full[brac_pkg::REL_W-1:0];

    // single-bit update mask
    assign bit_mask = brac_pkg::WORD_W'(1) << rel_reg[brac_pkg::BIT_W-1:0];

    // run mask for the word being filled
    assign fill_lo   = (fw_reg == start_rel_reg[brac_pkg::REL_W-1:brac_pkg::BIT_W])
                     ? start_rel_reg[brac_pkg::BIT_W-1:0] : '0;
    assign fill_last = (fw_reg == end_rel_reg[brac_pkg::REL_W-1:brac_pkg::BIT_W]);
    assign fill_hi   = fill_last ? end_rel_reg[brac_pkg::BIT_W-1:0]
                                 : brac_pkg::BIT_W'(brac_pkg::WORD_W - 1);
    assign fill_mask = ({brac_pkg::WORD_W{1'b1}} << fill_lo)
                     & ({brac_pkg::WORD_W{1'b1}}
                        >> (brac_pkg::BIT_W'(brac_pkg::WORD_W - 1) - fill_hi));

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        rel_next        = rel_reg;
        bcnt_next       = bcnt_reg;
        run_next        = run_reg;
        start_rel_next  = start_rel_reg;
        end_rel_next    = end_rel_reg;
        fw_next         = fw_reg;
        res_bit_next    = res_bit_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        mem_req         = '0;
        load_out        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_LOOKUP;
                end
            end

            S_LOOKUP:
            begin
                res_bit_next    = 1'b0;
                res_status_next = brac_pkg::ST_OK;
                res_start_next  = '0;
                bcnt_next       = '0;
                run_next        = '0;
                rel_next        = diff[brac_pkg::REL_W-1:0];
                unique case (func_reg)
                    brac_pkg::FN_TEST, brac_pkg::FN_SET:
                    begin
                        if (in_range)
                        begin
                            mem_req.re    = 1'b1;
                            mem_req.raddr = diff[brac_pkg::REL_W-1:brac_pkg::BIT_W];
                            state_next    = S_EXEC;
                        end
                        else
                        begin
                            res_status_next = brac_pkg::ST_RANGE;
                            state_next      = S_RESULT;
                        end
                    end
                    brac_pkg::FN_SCAN:
                    begin
                        res_status_next = brac_pkg::ST_NOTFOUND;
                        if ((want_reg == '0) || (nbytes_eff == '0))
                        begin
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            mem_req.re    = 1'b1;
                            mem_req.raddr = '0;
                            state_next    = S_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end

            S_EXEC:
            begin
                if (func_reg == brac_pkg::FN_TEST)
                begin
                    res_bit_next = rdata[rel_reg[brac_pkg::BIT_W-1:0]];
                end
                else
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = rel_reg[brac_pkg::REL_W-1:brac_pkg::BIT_W];
                    mem_req.wdata = nv_reg ? (rdata | bit_mask) : (rdata & ~bit_mask);
                end
                state_next = S_RESULT;
            end

            S_SCAN:
            begin
                run_next = scan_res.run_out;
                if (scan_res.hit)
                begin
                    start_rel_next = hit_start;
                    end_rel_next   = hit_end;
                    fw_next        = hit_start[brac_pkg::REL_W-1:brac_pkg::BIT_W];
                    mem_req.re     = 1'b1;
                    mem_req.raddr  = hit_start[brac_pkg::REL_W-1:brac_pkg::BIT_W];
                    state_next     = S_FILL;
                end
                else
                begin
                    bcnt_next = bcnt_inc;
                    if (bcnt_inc == nbytes_eff)
                    begin
                        state_next = S_RESULT;
                    end
                    else if (bcnt_inc[1:0] == 2'b00)
                    begin
                        // fetch the next map word
                        mem_req.re    = 1'b1;
                        mem_req.raddr = bcnt_inc[brac_pkg::WADDR_W+1:2];
                    end
                end
            end

            S_FILL:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = fw_reg;
                mem_req.wdata = rdata | fill_mask;
                if (fill_last)
                begin
                    res_status_next = brac_pkg::ST_OK;
                    res_start_next  = cfg.base_index + brac_pkg::IDX_W'(start_rel_reg);
                    state_next      = S_RESULT;
                end
                else
                begin
                    fw_next       = fw_reg + 1'b1;
                    mem_req.re    = 1'b1;
                    mem_req.raddr = fw_reg + 1'b1;
                end
            end

            S_RESULT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and work registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg  <= req.func;
            index_reg <= req.index;
            nv_reg    <= req.new_value;
            want_reg  <= req.run_length;
        end
        rel_reg        <= rel_next;
        bcnt_reg       <= bcnt_next;
        run_reg        <= run_next;
        start_rel_reg  <= start_rel_next;
        end_rel_reg    <= end_rel_next;
        fw_reg         <= fw_next;
        res_bit_reg    <= res_bit_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        if (load_out)
        begin
            out_bit_reg    <= res_bit_reg;
            out_status_reg <= res_status_reg;
            out_start_reg  <= res_start_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.bit_value   = out_bit_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.start_index = out_start_reg;

    // checks
    `BRAC_ASSERT_NOW(a_no_rw_clash, mem_req.re && mem_req.we, mem_req.raddr != mem_req.waddr)
    `BRAC_ASSERT_NOW(a_write_states, mem_req.we, (state_reg == S_EXEC) || (state_reg == S_FILL))
    `BRAC_ASSERT_NEXT(a_accept_lookup, in_accept, state_reg == S_LOOKUP)
    `BRAC_ASSERT_NOW(a_start_only_ok, rsp.valid && (rsp.status != brac_pkg::ST_OK), rsp.start_index == '0)

endmodule
